/* rtl/core/ipid_pkg.sv */
// ----------------------------------------------------------------------------
// ipid_pkg: shared types and constants of the incremental PID
// Field widths, register codes, reset values of the configuration registers
// and the setpoint scaling helper.
// ----------------------------------------------------------------------------
package ipid_pkg;

    localparam int SAMPLE_W = 16;  // Q3.12 setpoint and tilt
    localparam int ERR_W    = 18;  // Q12 error
    localparam int COEF_W   = 32;  // Q15.16 coefficient
    localparam int DRIVE_W  = 32;  // Q12 drive
    localparam int LIMIT_W  = 15;  // Q3.12 unsigned cutoff
    localparam int TERM_W   = ERR_W + COEF_W - 16;
    localparam int SUM_W    = TERM_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [2:0] CALL_WRAP = 3'd5;   // scale when count exceeds this
    localparam logic [2:0] CALL_MAX  = 3'd6;

    // floor(x * RECIP5 / 2^18) == floor(x / 5) for 0 <= x <= 32768
    localparam logic [31:0] RECIP5       = 32'd52429;
    localparam int          RECIP5_SHIFT = 18;

    localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 32'sd184383;
    localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -32'sd180119;
    localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = 32'sd1586;
    localparam logic [LIMIT_W-1:0]       TILT_LIMIT_RST = 15'd1393;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_NOW   = 3'd0,
        REG_COEF_PREV  = 3'd1,
        REG_COEF_PREV2 = 3'd2,
        REG_TILT_LIMIT = 3'd3
    } cfg_reg_t;

    // Word held between the front stage and the accumulate stage
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    cut;
    } stage_a_t;

    // Signed divide by 5, truncating toward zero
    function automatic logic signed [SAMPLE_W-1:0] div5_trunc(
        input logic signed [SAMPLE_W-1:0] r
    );
        logic [SAMPLE_W-1:0] mag;
        logic [31:0]         prod;
        logic [SAMPLE_W-1:0] q;
        mag  = r[SAMPLE_W-1] ? SAMPLE_W'(-r) : SAMPLE_W'(r);
        prod = 32'(mag) * RECIP5;
        q    = SAMPLE_W'(prod >> RECIP5_SHIFT);
        return r[SAMPLE_W-1] ? -$signed(q) : $signed(q);
    endfunction

endpackage

/* rtl/core/ipid_if.sv */
// ----------------------------------------------------------------------------
// ipid_if: valid/ready channels of the incremental PID
// Sample channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ipid_in_if
    import ipid_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [SAMPLE_W-1:0] measured_tilt;

    modport source (output valid, output setpoint, output measured_tilt, input ready);
    modport sink   (input valid, input setpoint, input measured_tilt, output ready);
endinterface

interface ipid_out_if
    import ipid_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

interface ipid_cfg_if
    import ipid_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/incremental_pid_tilt_cutoff.sv */
// ----------------------------------------------------------------------------
// incremental_pid_tilt_cutoff: velocity-form PID with tilt cutoff
// Top level: front stage, accumulate stage, configuration registers.
// ----------------------------------------------------------------------------
// Usage
//   sample: one word per control period, setpoint and measured tilt in Q3.12.
//   result: one drive word (Q12) per sample, in order.
//   cfg:    register writes (0 coef_now, 1 coef_prev, 2 coef_prev2,
//           3 tilt_limit); always ready, other indexes are dropped. Write
//           only while no sample is in flight.
// Timing
//   Two register stages: the front stage scales the setpoint, forms the
//   error and the cutoff flag; the accumulate stage runs three 18x32
//   multiplies, the sum and saturation into the result register. A drive
//   word is registered in the result register after its sample in a_reg.
//   One sample per cycle is sustained while the result is not held, since
//   the drive and error history close within the accumulate stage.
// Reset
//   Clears the history, the call count and both valid bits, and loads the
//   default coefficients and cutoff.
// Stall
//   A held result freezes the accumulate stage; the front stage still fills,
//   then sample.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module incremental_pid_tilt_cutoff
    import ipid_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ipid_in_if.sink   sample,
    ipid_out_if.source result,
    ipid_cfg_if.sink  cfg
);

    logic signed [COEF_W-1:0]  coef_now_reg;
    logic signed [COEF_W-1:0]  coef_prev_reg;
    logic signed [COEF_W-1:0]  coef_prev2_reg;
    logic [LIMIT_W-1:0]        tilt_limit_reg;

    logic [2:0]                call_count_reg;
    logic [2:0]                call_count_next;
    logic                      a_valid_reg;
    logic                      a_valid_next;
    stage_a_t                  a_reg;
    stage_a_t                  a_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [DRIVE_W-1:0] drive_reg;

    logic signed [DRIVE_W-1:0] prev_drive_reg;
    logic signed [ERR_W-1:0]   err_last_reg;
    logic signed [ERR_W-1:0]   err_before_last_reg;

    logic                      advance;
    logic                      accept;
    logic                      fire;
    logic                      scale;
    logic signed [SAMPLE_W-1:0] ref_val;
    logic [SAMPLE_W-1:0]       tilt_mag;
    logic signed [DRIVE_W-1:0] drive_sat;

    // ---------------- handshake ----------------
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = !a_valid_reg || advance;
    assign accept       = sample.valid && sample.ready;
    assign fire         = a_valid_reg && advance;
    assign cfg.ready    = 1'b1;

    assign a_valid_next   = accept || (a_valid_reg && !advance);
    assign out_valid_next = fire || (out_valid_reg && !result.ready);

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

    // ---------------- front stage ----------------
    assign scale   = call_count_reg > CALL_WRAP;
    assign ref_val = scale ? div5_trunc(sample.setpoint) : sample.setpoint;
    assign tilt_mag = sample.measured_tilt[SAMPLE_W-1] ? SAMPLE_W'(-sample.measured_tilt)
                                                       : SAMPLE_W'(sample.measured_tilt);

    always_comb
    begin
        a_next.err = ERR_W'(ref_val) - ERR_W'(sample.measured_tilt);
        a_next.cut = tilt_mag > {1'b0, tilt_limit_reg};
        if (!accept)
        begin
            call_count_next = call_count_reg;
        end
        else if (scale)
        begin
            call_count_next = 3'd1;
        end
        else
        begin
            call_count_next = call_count_reg + 3'd1;
        end
    end

    // ---------------- accumulate stage ----------------
    ipid_accum u_accum (
        .err             (a_reg.err),
        .err_last        (err_last_reg),
        .err_before_last (err_before_last_reg),
        .coef_now        (coef_now_reg),
        .coef_prev       (coef_prev_reg),
        .coef_prev2      (coef_prev2_reg),
        .prev_drive      (prev_drive_reg),
        .drive_sat       (drive_sat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg         <= 1'b0;
            out_valid_reg       <= 1'b0;
            call_count_reg      <= 3'd0;
            prev_drive_reg      <= '0;
            err_last_reg        <= '0;
            err_before_last_reg <= '0;
        end
        else
        begin
            a_valid_reg    <= a_valid_next;
            out_valid_reg  <= out_valid_next;
            call_count_reg <= call_count_next;
            if (fire)
            begin
                // history keeps the unforced drive
                prev_drive_reg      <= drive_sat;
                err_before_last_reg <= err_last_reg;
                err_last_reg        <= a_reg.err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= a_next;
        end
        if (fire)
        begin
            drive_reg <= a_reg.cut ? '0 : drive_sat;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_now_reg   <= COEF_NOW_RST;
            coef_prev_reg  <= COEF_PREV_RST;
            coef_prev2_reg <= COEF_PREV2_RST;
            tilt_limit_reg <= TILT_LIMIT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_COEF_NOW:   coef_now_reg   <= $signed(cfg.data);
                REG_COEF_PREV:  coef_prev_reg  <= $signed(cfg.data);
                REG_COEF_PREV2: coef_prev2_reg <= $signed(cfg.data);
                REG_TILT_LIMIT: tilt_limit_reg <= cfg.data[LIMIT_W-1:0];
                default:        ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("accumulate stage fired but result register is empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        call_count_reg <= CALL_MAX)
        else $error("call count out of range");

    a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && a_reg.cut) |=> (result.drive == '0))
        else $error("cutoff sample produced a nonzero drive");

    a_drive_history: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !a_reg.cut) |=> (result.drive == prev_drive_reg))
        else $error("delivered drive differs from stored history");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !advance) |-> !sample.ready)
        else $error("sample taken while front stage is full and stalled");

endmodule

/* rtl/core/ipid_accum.sv */
// ----------------------------------------------------------------------------
// ipid_accum: velocity-form accumulate
// Three error terms rescaled from Q28 to Q12, added to the previous drive and
// saturated to 32 bits.
// ----------------------------------------------------------------------------
module ipid_accum
    import ipid_pkg::*;
(
    input  logic signed [ERR_W-1:0]   err,
    input  logic signed [ERR_W-1:0]   err_last,
    input  logic signed [ERR_W-1:0]   err_before_last,
    input  logic signed [COEF_W-1:0]  coef_now,
    input  logic signed [COEF_W-1:0]  coef_prev,
    input  logic signed [COEF_W-1:0]  coef_prev2,
    input  logic signed [DRIVE_W-1:0] prev_drive,
    output logic signed [DRIVE_W-1:0] drive_sat
);

    logic signed [ERR_W+COEF_W-1:0] prod0;
    logic signed [ERR_W+COEF_W-1:0] prod1;
    logic signed [ERR_W+COEF_W-1:0] prod2;
    logic signed [TERM_W-1:0]       term0;
    logic signed [TERM_W-1:0]       term1;
    logic signed [TERM_W-1:0]       term2;
    logic signed [SUM_W-1:0]        sum;

    assign prod0 = err * coef_now;
    assign prod1 = err_last * coef_prev;
    assign prod2 = err_before_last * coef_prev2;

    // arithmetic shift floors toward minus infinity
    assign term0 = TERM_W'(prod0 >>> 16);
    assign term1 = TERM_W'(prod1 >>> 16);
    assign term2 = TERM_W'(prod2 >>> 16);

    assign sum = SUM_W'(term0) + SUM_W'(term1) + SUM_W'(term2) + SUM_W'(prev_drive);

    always_comb
    begin
        if (sum > SUM_W'(DRIVE_MAX))
        begin
            drive_sat = DRIVE_MAX;
        end
        else if (sum < SUM_W'(DRIVE_MIN))
        begin
            drive_sat = DRIVE_MIN;
        end
        else
        begin
            drive_sat = DRIVE_W'(sum);
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the incremental PID with tilt cutoff
// Pushes setpoint/tilt samples through the controller with random gaps on the
// sample side and random back-pressure on the drive side. A behavioral model
// of the velocity-form PID predicts every drive word, and the words are
// compared in order. Between phases the coefficients and the cutoff are
// rewritten, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import ipid_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;
    localparam int PIPE_LAT    = 2;
    localparam int TAIL_CYCLES = 8;
    localparam int N_PHASES    = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int N_DIRECTED  = 22;
    localparam int MAX_REPORTS = 10;

    localparam logic signed [COEF_W-1:0] COEF_TOP    = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] COEF_BOTTOM = 32'sh8000_0000;
    localparam logic [LIMIT_W-1:0]       LIMIT_TOP   = '1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] tilt;
        logic                       pinned;
        logic signed [DRIVE_W-1:0]  drive;
    } dir_row_t;

    // Runs on the reset coefficients and a cutoff of 1393. Pinned rows carry
    // a drive that is plain from the row itself: zero history, or cut off.
    dir_row_t dir_rows [0:N_DIRECTED-1] = '{
        '{0,      0,      1, 0},   // zero history, zero error
        '{4096,   0,      0, 0},
        '{4096,   1393,   0, 0},   // tilt right at the cutoff
        '{-4096,  -1393,  0, 0},
        '{0,      1394,   1, 0},   // just past the cutoff
        '{0,      -1394,  1, 0},
        '{-32768, 100,    0, 0},   // seventh call: setpoint scaled down
        '{32767,  -32768, 1, 0},   // most negative tilt always cuts
        '{-32768, 32767,  1, 0},
        '{32767,  0,      0, 0},
        '{-32768, 0,      0, 0},
        '{1,      -1,     0, 0},
        '{32767,  5,      0, 0},   // second scaling
        '{-1,     1,      0, 0},
        '{500,    0,      0, 0},
        '{0,      1393,   0, 0},
        '{0,      -1393,  0, 0},
        '{100,    200,    0, 0},
        '{-7,     0,      0, 0},   // third scaling, rounds toward zero
        '{-300,   0,      0, 0},
        '{-200,   -100,   0, 0},
        '{12,     0,      0, 0}
    };

    logic clk;
    logic rst_n;
    bit   quiet;

    ipid_in_if  sample_ch ();
    ipid_out_if result_ch ();
    ipid_cfg_if cfg_ch ();

    incremental_pid_tilt_cutoff i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // controller model: registers and history
    logic signed [COEF_W-1:0]  coef_now_m;
    logic signed [COEF_W-1:0]  coef_prev_m;
    logic signed [COEF_W-1:0]  coef_prev2_m;
    logic        [LIMIT_W-1:0] limit_m;
    logic signed [DRIVE_W-1:0] drive_hist;
    logic signed [ERR_W-1:0]   err1_hist;
    logic signed [ERR_W-1:0]   err2_hist;
    logic        [2:0]         call_cnt;

    logic signed [DRIVE_W-1:0] drive_due [$];

    int n_samples;
    int n_results;
    int n_bad;
    int n_cut;
    int n_sat;
    int n_settings;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void pid_reset();
        coef_now_m   = COEF_NOW_RST;
        coef_prev_m  = COEF_PREV_RST;
        coef_prev2_m = COEF_PREV2_RST;
        limit_m      = TILT_LIMIT_RST;
        drive_hist   = '0;
        err1_hist    = '0;
        err2_hist    = '0;
        call_cnt     = '0;
    endfunction

    function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [COEF_W-1:0] val);
        case (idx)
            REG_COEF_NOW:   coef_now_m   = val;
            REG_COEF_PREV:  coef_prev_m  = val;
            REG_COEF_PREV2: coef_prev2_m = val;
            REG_TILT_LIMIT: limit_m      = val[LIMIT_W-1:0];
            default: ;  // drop writes to unused indexes
        endcase
    endfunction

    // One control step: update the history and return the drive word.
    function automatic logic signed [DRIVE_W-1:0] pid_advance(
        input logic signed [SAMPLE_W-1:0] sp,
        input logic signed [SAMPLE_W-1:0] tilt
    );
        longint r;
        longint e;
        longint acc;
        longint mag;
        r = longint'(sp);
        if (call_cnt > CALL_WRAP)
        begin
            r        = r / 5;
            call_cnt = '0;
        end
        e   = r - longint'(tilt);
        // Q12 x Q16 products, floored back to Q12
        acc = ((e * longint'(coef_now_m)) >>> 16)
            + ((longint'(err1_hist) * longint'(coef_prev_m)) >>> 16)
            + ((longint'(err2_hist) * longint'(coef_prev2_m)) >>> 16)
            + longint'(drive_hist);
        if (acc > longint'(DRIVE_MAX) || acc < longint'(DRIVE_MIN))
            n_sat++;
        if (acc > longint'(DRIVE_MAX))
            acc = longint'(DRIVE_MAX);
        if (acc < longint'(DRIVE_MIN))
            acc = longint'(DRIVE_MIN);
        drive_hist = DRIVE_W'(acc);
        err2_hist  = err1_hist;
        err1_hist  = ERR_W'(e);
        call_cnt   = call_cnt + 3'd1;
        mag = (tilt < 0) ? -longint'(tilt) : longint'(tilt);
        if (mag > longint'(limit_m))
        begin
            n_cut++;
            return '0;
        end
        return drive_hist;
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        if (roll < 98)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        if ($urandom_range(3) == 0)
            return $urandom;
        // roughly +/-8.0 in Q15.16
        return COEF_W'(int'($urandom_range(1 << 20)) - (1 << 19));
    endfunction

    task automatic offer_sample(input logic signed [SAMPLE_W-1:0] sp,
                                input logic signed [SAMPLE_W-1:0] tilt,
                                input logic pinned,
                                input logic signed [DRIVE_W-1:0] pinned_drive);
        int                        gap;
        logic signed [DRIVE_W-1:0] want;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid         = 1'b1;
        sample_ch.setpoint      = sp;
        sample_ch.measured_tilt = tilt;
        do @(posedge clk); while (!sample_ch.ready);
        want = pid_advance(sp, tilt);
        if (pinned)
            want = pinned_drive;
        drive_due.push_back(want);
        n_samples++;
    endtask

    // Hold off the sender until every drive word has come back.
    task automatic settle_outputs();
        @(negedge clk);
        sample_ch.valid = 1'b0;
        while (drive_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge clk); while (!cfg_ch.ready);
        load_reg(idx, val);
    endtask

    task automatic setup_phase(input int p);
        logic [COEF_W-1:0]    c0;
        logic [COEF_W-1:0]    c1;
        logic [COEF_W-1:0]    c2;
        logic [LIMIT_W-1:0]   lim;
        logic [CFG_IDX_W-1:0] stray;
        case (p)
            0:
            begin
                c0 = COEF_TOP; c1 = COEF_BOTTOM; c2 = COEF_TOP; lim = LIMIT_TOP;
            end
            1:
            begin
                c0 = COEF_BOTTOM; c1 = COEF_TOP; c2 = COEF_BOTTOM; lim = '0;
            end
            2:
            begin
                c0  = COEF_NOW_RST;
                c1  = COEF_PREV_RST;
                c2  = COEF_PREV2_RST;
                lim = TILT_LIMIT_RST;
            end
            3:
            begin
                c0 = '0; c1 = '0; c2 = '0; lim = LIMIT_W'($urandom_range(4095));
            end
            default:
            begin
                c0  = pick_coef();
                c1  = pick_coef();
                c2  = pick_coef();
                lim = $urandom_range(1) ? LIMIT_W'($urandom_range(4095)) : LIMIT_W'($urandom);
            end
        endcase
        stray = CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(REG_TILT_LIMIT) + 1));
        write_reg(stray, $urandom);
        write_reg(REG_COEF_NOW, c0);
        write_reg(REG_COEF_PREV, c1);
        write_reg(REG_COEF_PREV2, c2);
        // upper data bits are don't-care for the cutoff
        write_reg(REG_TILT_LIMIT, {17'($urandom), lim});
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        n_settings++;
    endtask

    // drive side: random back-pressure
    initial
    begin
        int stall;
        stall           = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet)
            begin
                result_ch.ready = 1'b1;
            end
            else if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready = 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        logic signed [DRIVE_W-1:0] want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            n_results++;
            if (drive_due.size() == 0)
            begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected drive word %0d", result_ch.drive);
            end
            else
            begin
                want = drive_due.pop_front();
                if (result_ch.drive !== want)
                begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("drive word %0d: expected %0d, got %0d",
                                 n_results, want, result_ch.drive);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d drive words outstanding",
                     cycles, drive_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int lim;
        int t;
        int s;
        sample_ch.valid         = 1'b0;
        sample_ch.setpoint      = '0;
        sample_ch.measured_tilt = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        rst_n                   = 1'b0;
        quiet                   = 1'b0;
        pid_reset();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            offer_sample(dir_rows[i].setpoint, dir_rows[i].tilt,
                         dir_rows[i].pinned, dir_rows[i].drive);
        settle_outputs();

        for (int p = 0; p < N_PHASES; p++)
        begin
            setup_phase(p);
            quiet = (p % 3 == 2);
            lim   = int'(limit_m);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: t = int'($urandom_range(2 * lim)) - lim;
                    4:
                    begin
                        // on or just past the cutoff, either sign
                        t = lim + int'($urandom_range(1));
                        if ($urandom_range(1))
                            t = -t;
                    end
                    5: t = ($urandom_range(2) == 0) ? 0
                         : ($urandom_range(1) ? 32767 : -32768);
                    default: t = $urandom;
                endcase
                s = ($urandom_range(3) == 0) ? int'($urandom_range(128)) - 64 : $urandom;
                offer_sample(SAMPLE_W'(s), SAMPLE_W'(t), 1'b0, '0);
                if ($urandom_range(99) == 0)
                    settle_outputs();
            end
            settle_outputs();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (drive_due.size() != 0)
        begin
            $display("%0d drive words never arrived", drive_due.size());
            n_bad += drive_due.size();
        end
        $display("Ran %0d samples over %0d register settings: %0d cut off, %0d saturated",
                 n_samples, n_settings + 1, n_cut, n_sat);
        $display("Checked %0d drive words, %0d errors", n_results, n_bad);
        if (n_bad == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ipid_pkg.sv
rtl/core/ipid_if.sv
rtl/core/ipid_accum.sv
rtl/core/incremental_pid_tilt_cutoff.sv
bench/tb_top.sv
